// ----- hw/rtl/wosm_pkg.sv -----
// Shared constants, codes and controller/datapath command types for the stream merge.
package wosm_pkg;

  // Default geometry of the block.
  localparam int THREADS_DEF     = 4;
  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int TIME_BITS_DEF   = 48;

  // Fixed widths of the channel fields.
  localparam int OP_W   = 2;
  localparam int THR_W  = 3;
  localparam int TS_W   = 48;
  localparam int PL_W   = 32;
  localparam int STAT_W = 2;

  // Saturation limit of the active thread count.
  localparam int ACT_W   = 4;
  localparam int ACT_MAX = 15;

  // Entry kinds.
  typedef enum logic [OP_W-1:0] {
    OP_PLAIN  = 2'd0,
    OP_REGIST = 2'd1,
    OP_FINISH = 2'd2,
    OP_SYNC   = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_RELEASE = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_ORDER   = 2'd2
  } stat_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic update;
    logic wm_step;
    logic rel_step;
    logic pop;
    logic refill;
    logic emit_drop;
    logic emit_pend;
    logic pend_last;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic drop;
    logic rec;
    logic wm_last;
    logic rel_last;
    logic rel_ok;
    logic pend_valid;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- hw/rtl/wosm_in_if.sv -----
// Input channel carrying one parsed trace entry per beat.
interface wosm_in_if;
  import wosm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic signed [THR_W-1:0] thread;
  logic [TS_W-1:0]         timestamp;
  logic [PL_W-1:0]         payload;

  modport source (output valid, op, thread, timestamp, payload, input ready);
  modport sink   (input valid, op, thread, timestamp, payload, output ready);
endinterface

// ----- hw/rtl/wosm_out_if.sv -----
// Result channel carrying one released or dropped entry per beat.
interface wosm_out_if;
  import wosm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic signed [THR_W-1:0] out_thread;
  logic [TS_W-1:0]         out_time;
  logic [PL_W-1:0]         out_payload;
  logic                    last;

  modport source (output valid, status, out_thread, out_time, out_payload, last, input ready);
  modport sink   (input valid, status, out_thread, out_time, out_payload, last, output ready);
endinterface

// ----- hw/rtl/wosm_ctrl.sv -----
// Controller state machine that sequences check, update, scans and result beats.
module wosm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  wosm_pkg::dp_stat_t   stat,
  output wosm_pkg::ctrl_cmd_t  cmd
);
  import wosm_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CHECK  = 8'b0000_0010,
    S_DROP   = 8'b0000_0100,
    S_WM     = 8'b0000_1000,
    S_REL    = 8'b0001_0000,
    S_DECIDE = 8'b0010_0000,
    S_REFILL = 8'b0100_0000,
    S_FLUSH  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.drop) begin
          state_nxt = S_DROP;
        end else begin
          cmd.update = 1'b1;
          state_nxt  = stat.rec ? S_WM : S_REL;
        end
      end
      S_DROP: begin
        if (stat.out_free) begin
          cmd.emit_drop = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_WM: begin
        cmd.wm_step = 1'b1;
        if (stat.wm_last) state_nxt = S_REL;
      end
      S_REL: begin
        cmd.rel_step = 1'b1;
        if (stat.rel_last) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (!stat.rel_ok) begin
          state_nxt = stat.pend_valid ? S_FLUSH : S_IDLE;
        end else if (!stat.pend_valid || stat.out_free) begin
          cmd.pop       = 1'b1;
          cmd.emit_pend = stat.pend_valid;
          state_nxt     = S_REFILL;
        end
      end
      S_REFILL: begin
        cmd.refill = 1'b1;
        state_nxt  = S_REL;
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          cmd.emit_pend = 1'b1;
          cmd.pend_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hw/rtl/wosm_dp.sv -----
// Datapath: queue memories, head cache, thread table, watermark and result registers.
module wosm_dp #(
  parameter int THREADS     = wosm_pkg::THREADS_DEF,
  parameter int QUEUE_DEPTH = wosm_pkg::QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = wosm_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  wosm_pkg::ctrl_cmd_t               cmd,
  output wosm_pkg::dp_stat_t                stat,
  input  logic [wosm_pkg::OP_W-1:0]         in_op,
  input  logic signed [wosm_pkg::THR_W-1:0] in_thread,
  input  logic [wosm_pkg::TS_W-1:0]         in_timestamp,
  input  logic [wosm_pkg::PL_W-1:0]         in_payload,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [wosm_pkg::STAT_W-1:0]       out_status,
  output logic signed [wosm_pkg::THR_W-1:0] out_thread,
  output logic [wosm_pkg::TS_W-1:0]         out_time,
  output logic [wosm_pkg::PL_W-1:0]         out_payload,
  output logic                              out_last
);
  import wosm_pkg::*;

  localparam int NQ = THREADS + 1;
  localparam int QW = $clog2(NQ);
  localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(NQ * QUEUE_DEPTH);
  localparam int MD = NQ * QUEUE_DEPTH;

  // Latched input beat.
  op_t                  op_r;
  logic [QW-1:0]        q_r;
  logic                 thr_ok_r;
  logic [TIME_BITS-1:0] ts_r;
  logic [PL_W-1:0]      pl_r;

  // Per-queue control state and head cache.
  logic [PW-1:0]        rptr_r    [NQ];
  logic [PW-1:0]        wptr_r    [NQ];
  logic [FW-1:0]        fill_r    [NQ];
  logic                 done_r    [NQ];
  logic [TIME_BITS-1:0] lastenq_r [NQ];
  logic [TIME_BITS-1:0] head_t_r  [NQ];
  logic [PL_W-1:0]      head_pl_r [NQ];

  // Per-thread table and global counters.
  logic [TIME_BITS-1:0] latest_r [THREADS];
  logic                 live_r   [THREADS];
  logic [ACT_W-1:0]     act_r;
  logic [TIME_BITS-1:0] wm_r;

  // Scan state for the watermark and release searches; the scan counter sc_r is shared by both.
  logic [QW-1:0]        sc_r;
  logic                 any_r;
  logic [TIME_BITS-1:0] min_r;
  logic                 found_r;
  logic [QW-1:0]        best_r;
  logic [TIME_BITS-1:0] bt_r;
  logic [PL_W-1:0]      bpl_r;
  logic [FW-1:0]        bfill_r;
  logic [PW-1:0]        brptr_r;
  logic                 bdone_r;

  // Entry waiting for its last flag.
  logic                 pend_valid_r;
  logic [QW-1:0]        pend_q_r;
  logic [TIME_BITS-1:0] pend_t_r;
  logic [PL_W-1:0]      pend_pl_r;

  // Queue storage.
  logic [TIME_BITS-1:0] tmem [MD];
  logic [PL_W-1:0]      pmem [MD];
  logic [TIME_BITS-1:0] rd_t_r;
  logic [PL_W-1:0]      rd_pl_r;

  // Result register.
  logic                 out_valid_r;
  logic [STAT_W-1:0]    out_status_r;
  logic [THR_W-1:0]     out_thread_r;
  logic [TS_W-1:0]      out_time_r;
  logic [PL_W-1:0]      out_payload_r;
  logic                 out_last_r;

  logic                 thr_in_ok;
  logic [QW-1:0]        q_in;
  logic                 enq;
  logic [TW-1:0]        ti;
  logic [FW-1:0]        fill_q;
  logic                 drop_full;
  logic                 drop_ord;
  logic [TW-1:0]        wi;
  logic                 any_in;
  logic                 wm_take;
  logic                 fnd_in;
  logic                 rel_take;
  logic [PW-1:0]        np;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr;
  logic                 out_free;

  // Thread slot normalization: out-of-range slots fall back to the unregistered queue.
  assign thr_in_ok = !in_thread[THR_W-1] && (int'(in_thread[THR_W-2:0]) < THREADS);
  assign q_in      = thr_in_ok ? QW'(in_thread[THR_W-2:0]) + QW'(1) : '0;

  // Drop checks on the latched beat.
  assign enq       = !(op_r == OP_SYNC && thr_ok_r);
  assign ti        = TW'(q_r - QW'(1));
  assign fill_q    = fill_r[q_r];
  assign drop_full = enq && (fill_q >= FW'(QUEUE_DEPTH));
  assign drop_ord  = enq && !drop_full && ((ts_r <= lastenq_r[q_r]) || done_r[q_r]);

  // Watermark scan step.
  assign wi      = TW'(sc_r);
  assign any_in  = (sc_r != '0) && any_r;
  assign wm_take = live_r[wi] && (!any_in || latest_r[wi] < min_r);

  // Release scan step: lowest timestamp wins, earlier queue on ties.
  assign fnd_in   = (sc_r != '0) && found_r;
  assign rel_take = (fill_r[sc_r] != '0) && (!fnd_in || head_t_r[sc_r] < bt_r);

  assign np    = (brptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : brptr_r + PW'(1);
  assign waddr = AW'(32'(q_r) * QUEUE_DEPTH + 32'(wptr_r[q_r]));
  assign raddr = AW'(32'(best_r) * QUEUE_DEPTH + 32'(np));

  assign out_free = !out_valid_r || out_ready;

  // Status to the controller.
  always_comb begin
    stat            = '0;
    stat.drop       = drop_full || drop_ord;
    stat.rec        = thr_ok_r &&
                      (op_r == OP_FINISH || !live_r[ti] || latest_r[ti] <= wm_r);
    stat.wm_last    = (sc_r == QW'(THREADS - 1));
    stat.rel_last   = (sc_r == QW'(NQ - 1));
    stat.rel_ok     = found_r && (act_r == '0 || bt_r <= wm_r);
    stat.pend_valid = pend_valid_r;
    stat.out_free   = out_free;
  end

  // Input latch; payload registers need no reset.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r     <= op_t'(in_op);
      q_r      <= q_in;
      thr_ok_r <= thr_in_ok;
      ts_r     <= TIME_BITS'(in_timestamp);
      pl_r     <= in_payload;
    end
  end

  // Queue storage: written on enqueue, next head read on pop.
  always_ff @(posedge clk) begin
    if (cmd.update && enq) begin
      tmem[waddr] <= ts_r;
      pmem[waddr] <= pl_r;
    end
    if (cmd.pop) begin
      rd_t_r  <= tmem[raddr];
      rd_pl_r <= pmem[raddr];
    end
  end

  // Head cache and scan working registers.
  always_ff @(posedge clk) begin
    if (cmd.update && enq && fill_q == '0) begin
      head_t_r[q_r]  <= ts_r;
      head_pl_r[q_r] <= pl_r;
    end
    if (cmd.refill) begin
      head_t_r[best_r]  <= rd_t_r;
      head_pl_r[best_r] <= rd_pl_r;
    end
    if (cmd.wm_step && wm_take) begin
      min_r <= latest_r[wi];
    end
    if (cmd.rel_step) begin
      found_r <= fnd_in || (fill_r[sc_r] != '0);
      if (rel_take) begin
        best_r  <= sc_r;
        bt_r    <= head_t_r[sc_r];
        bpl_r   <= head_pl_r[sc_r];
        bfill_r <= fill_r[sc_r];
        brptr_r <= rptr_r[sc_r];
        bdone_r <= done_r[sc_r];
      end
    end
    if (cmd.pop) begin
      pend_q_r  <= best_r;
      pend_t_r  <= bt_r;
      pend_pl_r <= bpl_r;
    end
  end

  // Queue control, thread table, watermark and scan counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NQ; i++) begin
        rptr_r[i]    <= '0;
        wptr_r[i]    <= '0;
        fill_r[i]    <= '0;
        done_r[i]    <= 1'b0;
        lastenq_r[i] <= '0;
      end
      for (int i = 0; i < THREADS; i++) begin
        latest_r[i] <= '0;
        live_r[i]   <= 1'b0;
      end
      act_r        <= '0;
      wm_r         <= '0;
      sc_r         <= '0;
      any_r        <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      // Apply an accepted entry.
      if (cmd.update) begin
        if (op_r == OP_REGIST && act_r != ACT_W'(ACT_MAX)) act_r <= act_r + ACT_W'(1);
        if (op_r == OP_FINISH && act_r != '0) act_r <= act_r - ACT_W'(1);
        if (thr_ok_r) begin
          if (op_r == OP_FINISH) begin
            live_r[ti] <= 1'b0;
          end else begin
            live_r[ti]   <= 1'b1;
            latest_r[ti] <= ts_r;
          end
        end
        if (enq) begin
          wptr_r[q_r]    <= (wptr_r[q_r] == PW'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wptr_r[q_r] + PW'(1);
          fill_r[q_r]    <= fill_q + FW'(1);
          lastenq_r[q_r] <= ts_r;
          if (op_r == OP_FINISH) done_r[q_r] <= 1'b1;
        end
      end
      // Watermark recompute over live threads; kept when none is live.
      if (cmd.wm_step) begin
        any_r <= any_in || live_r[wi];
        if (stat.wm_last) begin
          sc_r <= '0;
          if (any_in || live_r[wi]) wm_r <= wm_take ? latest_r[wi] : min_r;
        end else begin
          sc_r <= sc_r + QW'(1);
        end
      end
      if (cmd.rel_step) begin
        sc_r <= stat.rel_last ? '0 : sc_r + QW'(1);
      end
      // Release the selected head.
      if (cmd.pop) begin
        rptr_r[best_r] <= np;
        fill_r[best_r] <= bfill_r - FW'(1);
        if (bfill_r == FW'(1) && bdone_r) begin
          done_r[best_r]    <= 1'b0;
          lastenq_r[best_r] <= '0;
        end
        pend_valid_r <= 1'b1;
      end else if (cmd.emit_pend) begin
        pend_valid_r <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_drop || cmd.emit_pend) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_drop) begin
      out_status_r  <= drop_full ? STAT_FULL : STAT_ORDER;
      out_thread_r  <= THR_W'(32'(q_r) - 32'd1);
      out_time_r    <= TS_W'(ts_r);
      out_payload_r <= pl_r;
      out_last_r    <= 1'b1;
    end else if (cmd.emit_pend) begin
      out_status_r  <= STAT_RELEASE;
      out_thread_r  <= THR_W'(32'(pend_q_r) - 32'd1);
      out_time_r    <= TS_W'(pend_t_r);
      out_payload_r <= pend_pl_r;
      out_last_r    <= cmd.pend_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_thread  = out_thread_r;
  assign out_time    = out_time_r;
  assign out_payload = out_payload_r;
  assign out_last    = out_last_r;

endmodule

// ----- hw/rtl/watermark_ordered_stream_merge.sv -----
// Top level of the watermark-ordered stream merge: controller plus datapath.
//
// Merges per-thread trace entries into one timestamp-ordered stream. Each thread slot, plus one
// slot for unregistered threads, has a queue of QUEUE_DEPTH entries in a shared memory, and the
// head of each queue is cached in registers. One input beat is taken at a time, and the cycle
// after acceptance checks and applies the entry. A dropped entry presents its error beat once the
// output register is free. Otherwise the watermark is recomputed when the entry may move it, then
// each released entry takes a sequential scan over the THREADS+1 queue heads, a pop, and a head
// reload from the memory, and a final scan ends the search; the held entry is handed over when
// anything was released. The last released entry is held back one scan so that it can be flagged
// last. An entry that releases nothing gives no beat. Result beats wait in an output register, so
// stalls on the result side only stop the controller when a new beat is due.
module watermark_ordered_stream_merge #(
  parameter int THREADS     = wosm_pkg::THREADS_DEF,
  parameter int QUEUE_DEPTH = wosm_pkg::QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = wosm_pkg::TIME_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  wosm_in_if.sink    in_if,
  wosm_out_if.source out_if
);
  import wosm_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencer.
  wosm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Queues, thread table and result register.
  wosm_dp #(
    .THREADS     (THREADS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_op        (in_if.op),
    .in_thread    (in_if.thread),
    .in_timestamp (in_if.timestamp),
    .in_payload   (in_if.payload),
    .out_ready    (out_if.ready),
    .out_valid    (out_if.valid),
    .out_status   (out_if.status),
    .out_thread   (out_if.out_thread),
    .out_time     (out_if.out_time),
    .out_payload  (out_if.out_payload),
    .out_last     (out_if.last)
  );

endmodule

// ----- test/watermark_ordered_stream_merge_checker.sv -----
// Checker for the stream merge: predicts the released and dropped beats and compares them.
`timescale 1ns / 1ps
module watermark_ordered_stream_merge_checker (
  input  logic   clk,
  input  logic   rst_n,
  wosm_in_if     in_if,
  wosm_out_if    out_if,
  output int     fail_count,
  output int     pending_count
);
  import wosm_pkg::*;

  localparam int NTHR = THREADS_DEF;
  localparam int NQ   = NTHR + 1;
  localparam int QD   = QUEUE_DEPTH_DEF;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [THR_W-1:0] thread;
    logic [TS_W-1:0]         ts;
    logic [PL_W-1:0]         pl;
    logic                    last;
  } merge_beat_t;

  // Shadow copy of the queues, threads and watermark.
  logic [TS_W-1:0] q_time [NQ][$];
  logic [PL_W-1:0] q_pl   [NQ][$];
  logic            q_done [NQ];
  logic [TS_W-1:0] q_last [NQ];
  logic [TS_W-1:0] thr_latest [NTHR];
  logic            thr_live   [NTHR];
  int unsigned     active_thr;
  logic [TS_W-1:0] wmark;
  merge_beat_t     merged_beats [$];

  assign pending_count = merged_beats.size();

  // The watermark becomes the lowest latest time over live threads, if any.
  function automatic void refresh_watermark();
    logic            any;
    logic [TS_W-1:0] m;
    any = 0;
    m = '0;
    for (int i = 0; i < NTHR; i++)
      if (thr_live[i] && (!any || thr_latest[i] < m)) begin
        m = thr_latest[i];
        any = 1;
      end
    if (any) wmark = m;
  endfunction

  function automatic void merge_entry(logic [OP_W-1:0] op, logic signed [THR_W-1:0] raw,
                                      logic [TS_W-1:0] ts, logic [PL_W-1:0] pl);
    int          t;
    int          q;
    int          best;
    int          n;
    logic        enq;
    logic [STAT_W-1:0] st;
    logic [TS_W-1:0] bt;
    merge_beat_t b;
    t = int'(raw);
    if (t < 0 || t >= NTHR) t = -1;
    q = t + 1;
    enq = !(op == OP_SYNC && t >= 0);
    if (enq) begin
      st = STAT_RELEASE;
      if (q_time[q].size() >= QD) st = STAT_FULL;
      else if (ts <= q_last[q] || q_done[q]) st = STAT_ORDER;
      if (st != STAT_RELEASE) begin
        b = '{st, THR_W'(t), ts, pl, 1'b1};
        merged_beats = {merged_beats, b};
        return;
      end
    end
    if (op == OP_REGIST) begin
      if (active_thr < ACT_MAX) active_thr++;
    end else if (op == OP_FINISH) begin
      if (active_thr > 0) active_thr--;
      if (t >= 0) begin
        thr_live[t] = 0;
        refresh_watermark();
      end
    end
    if (op != OP_FINISH && t >= 0) begin
      if (!thr_live[t]) begin
        thr_live[t] = 1;
        thr_latest[t] = ts;
        refresh_watermark();
      end else begin
        if (thr_latest[t] <= wmark) begin
          thr_latest[t] = ts;
          refresh_watermark();
        end else thr_latest[t] = ts;
      end
    end
    if (enq) begin
      q_time[q] = {q_time[q], ts};
      q_pl[q] = {q_pl[q], pl};
      q_last[q] = ts;
      if (op == OP_FINISH) q_done[q] = 1;
    end
    // Release heads in time order, lowest slot on ties.
    n = 0;
    forever begin
      best = -1;
      bt = '0;
      for (int i = 0; i < NQ; i++)
        if (q_time[i].size() != 0 && (best < 0 || q_time[i][0] < bt)) begin
          best = i;
          bt = q_time[i][0];
        end
      if (best < 0) break;
      if (active_thr != 0 && bt > wmark) break;
      if (n >= NQ * QD) break;
      b = '{STAT_RELEASE, THR_W'(best - 1), q_time[best].pop_front(),
            q_pl[best].pop_front(), 1'b0};
      merged_beats = {merged_beats, b};
      n++;
      if (q_time[best].size() == 0 && q_done[best]) begin
        q_done[best] = 0;
        q_last[best] = '0;
      end
    end
    if (n > 0) merged_beats[$].last = 1'b1;
  endfunction

  merge_beat_t got, want;

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NQ; i++) begin
        q_time[i].delete();
        q_pl[i].delete();
        q_done[i] = 0;
        q_last[i] = '0;
      end
      for (int i = 0; i < NTHR; i++) begin
        thr_latest[i] = '0;
        thr_live[i] = 0;
      end
      active_thr = 0;
      wmark = '0;
      merged_beats.delete();
      fail_count = 0;
    end else begin
      // Compare first: a result beat always trails the input beat that caused it.
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.status, out_if.out_thread, out_if.out_time, out_if.out_payload,
                out_if.last};
        if (merged_beats.size() == 0) begin
          $display("%0t: result beat expected none actual %h", $time, got);
          fail_count++;
        end else begin
          want = merged_beats.pop_front();
          if (got.status !== want.status)
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          if (got.thread !== want.thread)
            $display("%0t: thread expected %0d actual %0d", $time, want.thread, got.thread);
          if (got.ts !== want.ts)
            $display("%0t: time expected %h actual %h", $time, want.ts, got.ts);
          if (got.pl !== want.pl)
            $display("%0t: payload expected %h actual %h", $time, want.pl, got.pl);
          if (got.last !== want.last)
            $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
          if (got !== want) fail_count++;
        end
      end
      if (in_if.valid && in_if.ready)
        merge_entry(in_if.op, in_if.thread, in_if.timestamp, in_if.payload);
    end
  end
endmodule

// ----- test/watermark_ordered_stream_merge_tb.sv -----
// Testbench top: clock, reset, entry stimulus with stalls, and the final verdict.
`timescale 1ns / 1ps
module watermark_ordered_stream_merge_tb;
  import wosm_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  int   fail_count;
  int   pending_count;
  int   cycle_count = 0;
  logic calm = 0;
  logic hold_long = 0;
  logic [TS_W-1:0] next_ts [-1:3];

  wosm_in_if  in_if ();
  wosm_out_if out_if ();

  watermark_ordered_stream_merge dut (.clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if));
  watermark_ordered_stream_merge_checker chk (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if),
    .fail_count(fail_count), .pending_count(pending_count));

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Generous cycle limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("** watermark_ordered_stream_merge: FAILED **");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off, none near the end.
  initial begin
    int gap;
    out_if.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_long) begin
        out_if.ready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_long = 0;
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        gap = $urandom_range(1, 5);
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Offer one entry and hold it until accepted, with random gaps ahead of it.
  task automatic send_entry(logic [OP_W-1:0] op, logic signed [THR_W-1:0] thr,
                            logic [TS_W-1:0] ts, logic [PL_W-1:0] pl);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.op        <= op;
    in_if.thread    <= thr;
    in_if.timestamp <= ts;
    in_if.payload   <= pl;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  function automatic logic [PL_W-1:0] rand_pl();
    return PL_W'({$urandom, $urandom} >> ($urandom_range(0, 1) * 16));
  endfunction

  // Mostly increasing time per slot, occasionally stale or random.
  task automatic random_entry();
    logic signed [THR_W-1:0] thr;
    logic [OP_W-1:0] op;
    logic [TS_W-1:0] ts;
    int s;
    int k;
    thr = THR_W'($urandom_range(0, 7));
    s = int'(thr);
    if (s < 0 || s > 3) s = -1;
    k = $urandom_range(0, 19);
    op = (k < 11) ? OP_PLAIN : (k < 14) ? OP_REGIST : (k < 16) ? OP_FINISH : OP_SYNC;
    if ($urandom_range(0, 19) == 0) ts = TS_W'({$urandom, $urandom});
    else if ($urandom_range(0, 19) == 0) ts = next_ts[s] - $urandom_range(0, 3);
    else begin
      next_ts[s] = next_ts[s] + $urandom_range(1, 6);
      ts = next_ts[s];
    end
    send_entry(op, thr, ts, rand_pl());
  endtask

  initial begin
    for (int i = -1; i <= 3; i++) next_ts[i] = 0;
    in_if.valid     <= 1'b0;
    in_if.op        <= OP_PLAIN;
    in_if.thread    <= '0;
    in_if.timestamp <= '0;
    in_if.payload   <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero time drop, unregistered and out-of-range slots, all kinds.
    send_entry(OP_PLAIN, -3'sd1, '0, 32'h0);
    send_entry(OP_PLAIN, -3'sd1, 48'd5, 32'hFFFF_FFFF);
    send_entry(OP_PLAIN, -3'sd4, 48'd6, 32'h1234_5678);
    send_entry(OP_REGIST, 3'sd0, 48'd10, 32'hA5A5_A5A5);
    send_entry(OP_REGIST, 3'sd1, 48'd20, 32'h5A5A_5A5A);
    send_entry(OP_PLAIN, 3'sd0, 48'd15, 32'h1);
    send_entry(OP_PLAIN, 3'sd0, 48'd15, 32'h2);
    send_entry(OP_SYNC, 3'sd1, 48'd30, 32'h3);
    send_entry(OP_SYNC, -3'sd1, 48'd31, 32'h4);
    send_entry(OP_FINISH, 3'sd0, 48'd40, 32'h5);
    send_entry(OP_PLAIN, 3'sd0, 48'd50, 32'h6);
    send_entry(OP_FINISH, 3'sd2, 48'd1, 32'h7);
    send_entry(OP_FINISH, -3'sd1, 48'd60, 32'h8);
    send_entry(OP_REGIST, -3'sd1, 48'd61, 32'h9);
    send_entry(OP_REGIST, 3'sd3, 48'hFFFF_FFFF_FFFF, 32'hA);
    for (int i = 0; i < 9; i++) send_entry(OP_PLAIN, 3'sd1, 48'd100 + i, 32'h100 + i);
    send_entry(OP_FINISH, 3'sd1, 48'd200, 32'hB);
    send_entry(OP_FINISH, 3'sd3, 48'hFFFF_FFFF_FFFF, 32'hC);
    for (int i = -1; i <= 3; i++) next_ts[i] = 48'd300;

    // Long receiver hold-off so the output backs up and input stalls.
    hold_long = 1;
    for (int i = 0; i < 220; i++) begin
      if (i == 176) calm = 1;
      random_entry();
    end
    // Drain: finish every thread so nothing stays held behind the watermark.
    for (int s = 0; s < 4; s++) begin
      next_ts[s] = next_ts[s] + 1;
      send_entry(OP_FINISH, THR_W'(s), next_ts[s], 32'hD);
    end
    in_if.valid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("** watermark_ordered_stream_merge: PASSED **");
    else
      $display("** watermark_ordered_stream_merge: FAILED **");
    $finish;
  end
endmodule
